/* rtl/pba_pkg.sv */
`default_nettype none

package pba_pkg;

  // Default sizing
  localparam int MAX_PAGES_DEF  = 4096;
  localparam int PAGE_BYTES_DEF = 4096;

  // Fixed field widths
  localparam int PAGE_COUNT_W = 13;
  localparam int ADDR_W       = 32;
  localparam int STATUS_W     = 2;
  localparam int CFG_INDEX_W  = 1;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_PAGE  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_FREE = 2'd2;

  // Request type codes
  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_PAGE_COUNT  = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_REGION_BASE = 1'b1;

  // Commands from controller to datapath
  typedef struct packed {
    logic                clear_wr;
    logic                load;
    logic                scan;
    logic                mark;
    logic                form_addr;
    logic                free_rd;
    logic                free_wr;
    logic                out_load;
    logic                out_use_addr;
    logic [STATUS_W-1:0] out_status;
  } pba_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic clr_last;
    logic empty;
    logic hit;
    logic scan_end;
    logic free_bad;
  } pba_stat_t;

endpackage

`default_nettype wire

/* rtl/page_bitmap_allocator.sv */
// Allocate: words are scanned from word 0 up to the last managed word, 1 word/cycle
//   (words = ceil(managed pages / 32)); the first free page found is marked, else ST_NO_PAGE.
// Free: the index is a shift; it is range-checked (ST_BAD_FREE), then its bit is cleared.
// One request in flight; the next can be accepted from the cycle after the result is loaded,
//   and a stalled earlier result delays that load. Reset (rst, synchronous): config cleared,
//   then a pass zeroes each bitmap word (MAX_PAGES/32 words, 128 by default) with in_stall high.
`default_nettype none

module page_bitmap_allocator
  import pba_pkg::*;
#(
  parameter int MAX_PAGES  = MAX_PAGES_DEF,
  parameter int PAGE_BYTES = PAGE_BYTES_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic                   req_type,
  input  wire logic [ADDR_W-1:0]      free_address,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic [ADDR_W-1:0]           page_address,
  output logic [STATUS_W-1:0]         status,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [ADDR_W-1:0]      cfg_data
);

  pba_cmd_t  cmd;
  pba_stat_t stat;

  // Configuration writes never wait
  assign cfg_ready = 1'b1;

  pba_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .req_type  (req_type),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .stat      (stat)
  );

  pba_datapath #(
    .MAX_PAGES  (MAX_PAGES),
    .PAGE_BYTES (PAGE_BYTES)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .free_address (free_address),
    .cfg_wr       (cfg_valid && cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .page_address (page_address),
    .status       (status)
  );

endmodule

`default_nettype wire

/* rtl/pba_ctrl.sv */
`default_nettype none

module pba_ctrl
  import pba_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire logic      req_type,
  output logic           out_valid,
  input  wire logic      out_stall,
  output pba_cmd_t       cmd,
  input  wire pba_stat_t stat
);

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_SCAN  = 4'd2;
  localparam logic [3:0] S_MARK  = 4'd3;
  localparam logic [3:0] S_ADDR  = 4'd4;
  localparam logic [3:0] S_FCHK  = 4'd6;
  localparam logic [3:0] S_FWR   = 4'd7;
  localparam logic [3:0] S_DONE  = 4'd8;

  logic [3:0]          state;
  logic [3:0]          state_next;
  logic [STATUS_W-1:0] res_status;
  logic [STATUS_W-1:0] res_status_next;
  logic                res_use_addr;
  logic                res_use_addr_next;
  logic                out_valid_next;
  logic                accept;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;

  // Sequence one request at a time
  always_comb begin
    state_next        = state;
    res_status_next   = res_status;
    res_use_addr_next = res_use_addr;
    cmd               = '0;
    cmd.out_status    = res_status;
    cmd.out_use_addr  = res_use_addr;
    unique case (state)
      S_CLEAR: begin
        cmd.clear_wr = 1'b1;
        if (stat.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          cmd.load          = 1'b1;
          res_use_addr_next = 1'b0;
          if (req_type == REQ_FREE) begin
            state_next = S_FCHK;
          end else if (stat.empty) begin
            res_status_next = ST_NO_PAGE;
            state_next      = S_DONE;
          end else begin
            state_next = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.hit) begin
          state_next = S_MARK;
        end else if (stat.scan_end) begin
          res_status_next = ST_NO_PAGE;
          state_next      = S_DONE;
        end
      end
      S_MARK: begin
        cmd.mark   = 1'b1;
        state_next = S_ADDR;
      end
      S_ADDR: begin
        cmd.form_addr     = 1'b1;
        res_status_next   = ST_OK;
        res_use_addr_next = 1'b1;
        state_next        = S_DONE;
      end
      S_FCHK: begin
        if (stat.free_bad) begin
          res_status_next = ST_BAD_FREE;
          state_next      = S_DONE;
        end else begin
          cmd.free_rd = 1'b1;
          state_next  = S_FWR;
        end
      end
      S_FWR: begin
        cmd.free_wr     = 1'b1;
        res_status_next = ST_OK;
        state_next      = S_DONE;
      end
      S_DONE: begin
        if (!out_valid || !out_stall) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Hold result valid until taken
  always_comb begin
    if (cmd.out_load) begin
      out_valid_next = 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      out_valid    <= 1'b0;
      res_status   <= ST_OK;
      res_use_addr <= 1'b0;
    end else begin
      state        <= state_next;
      out_valid    <= out_valid_next;
      res_status   <= res_status_next;
      res_use_addr <= res_use_addr_next;
    end
  end

endmodule

`default_nettype wire

/* rtl/pba_datapath.sv */
`default_nettype none

module pba_datapath
  import pba_pkg::*;
#(
  parameter int MAX_PAGES  = MAX_PAGES_DEF,
  parameter int PAGE_BYTES = PAGE_BYTES_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire pba_cmd_t               cmd,
  output pba_stat_t                   stat,
  input  wire logic [ADDR_W-1:0]      free_address,
  input  wire logic                   cfg_wr,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [ADDR_W-1:0]      cfg_data,
  output logic [ADDR_W-1:0]           page_address,
  output logic [STATUS_W-1:0]         status
);

  localparam int MAP_WORDS = (MAX_PAGES + 31) / 32;
  localparam int WW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int PW        = WW + 5;
  localparam int NW        = $clog2(MAX_PAGES + 1);
  // Page size must be a power of two (the block does not check it); the page index is a plain shift
  localparam int RW        = $clog2(PAGE_BYTES);

  // Index of the single set bit of a one-hot word
  function automatic logic [4:0] onehot_index(input logic [31:0] oh);
    logic [4:0] idx;
    idx = '0;
    for (int i = 0; i < 32; i++) begin
      if (oh[i]) begin
        idx = idx | 5'(i);
      end
    end
    return idx;
  endfunction

  logic [31:0]             used_map [MAP_WORDS];
  logic [31:0]             rdata;
  logic                    rd_en;
  logic [WW-1:0]           rd_addr;
  logic                    wr_en;
  logic [WW-1:0]           wr_addr;
  logic [31:0]             wr_data;

  logic [PAGE_COUNT_W-1:0] page_count;
  logic [ADDR_W-1:0]       region_base;
  logic [NW-1:0]           n;
  logic [NW:0]             words;
  logic [NW:0]             words_m1;
  logic [WW-1:0]           last_w;
  logic [4:0]              tail;

  logic [WW-1:0]           clr_cnt;
  logic [WW-1:0]           chk_w;
  logic [WW-1:0]           nxt_w;
  logic [31:0]             valid_mask;
  logic [31:0]             free_bits;
  logic [31:0]             iso;
  logic [4:0]              hit_bit;
  logic [31:0]             mark_word;
  logic [ADDR_W-1:0]       prod;
  logic [ADDR_W-1:0]       res_addr;

  logic [ADDR_W-1:0]       dq;
  logic [WW-1:0]           free_w;
  logic [4:0]              free_b;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      page_count  <= '0;
      region_base <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_index)
        REG_PAGE_COUNT:  page_count  <= cfg_data[PAGE_COUNT_W-1:0];
        REG_REGION_BASE: region_base <= cfg_data;
        default: ;
      endcase
    end
  end

  // Clamp the managed count and derive the scan bounds
  always_comb begin
    if (32'(page_count) > 32'(MAX_PAGES)) begin
      n = NW'(MAX_PAGES);
    end else begin
      n = NW'(page_count);
    end
    words    = ({1'b0, n} + (NW+1)'(31)) >> 5;
    words_m1 = words - (NW+1)'(1);
    last_w   = words_m1[WW-1:0];
    tail     = n[4:0];
  end

  // Look for a free page in the word just read
  always_comb begin
    if ((chk_w == last_w) && (tail != 5'd0)) begin
      valid_mask = (32'd1 << tail) - 32'd1;
    end else begin
      valid_mask = '1;
    end
    free_bits = ~rdata & valid_mask;
    iso       = free_bits & (~free_bits + 32'd1);
    if (chk_w == WW'(MAP_WORDS - 1)) begin
      nxt_w = chk_w;
    end else begin
      nxt_w = chk_w + WW'(1);
    end
  end

  assign free_w = dq[PW-1:5];
  assign free_b = dq[4:0];

  // Status to controller
  always_comb begin
    stat          = '0;
    stat.clr_last = (clr_cnt == WW'(MAP_WORDS - 1));
    stat.empty    = (n == '0);
    stat.hit      = (free_bits != 32'd0);
    stat.scan_end = (chk_w == last_w);
    stat.free_bad = (dq >= 32'(n));
  end

  // Select bitmap read address
  always_comb begin
    rd_en   = cmd.load || cmd.scan || cmd.free_rd;
    rd_addr = '0;
    priority if (cmd.scan) begin
      rd_addr = nxt_w;
    end else if (cmd.free_rd) begin
      rd_addr = free_w;
    end else begin
      rd_addr = '0;
    end
  end

  // Select bitmap write
  always_comb begin
    wr_en   = cmd.clear_wr || cmd.mark || cmd.free_wr;
    wr_addr = '0;
    wr_data = '0;
    priority if (cmd.clear_wr) begin
      wr_addr = clr_cnt;
    end else if (cmd.mark) begin
      wr_addr = chk_w;
      wr_data = mark_word;
    end else if (cmd.free_wr) begin
      wr_addr = free_w;
      wr_data = rdata & ~(32'd1 << free_b);
    end else begin
      wr_addr = '0;
    end
  end

  // Bitmap storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      used_map[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata <= used_map[rd_addr];
    end
  end

  // Advance the clearing pass
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clear_wr && !stat.clr_last) begin
      clr_cnt <= clr_cnt + WW'(1);
    end
  end

  // Scan, mark and form the page address
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      chk_w <= '0;
    end else if (cmd.scan && !stat.hit) begin
      chk_w <= nxt_w;
    end
    if (cmd.scan && stat.hit) begin
      hit_bit   <= onehot_index(iso);
      mark_word <= rdata | iso;
    end
    if (cmd.mark) begin
      prod <= 32'({chk_w, hit_bit}) * 32'(PAGE_BYTES);
    end
    if (cmd.form_addr) begin
      res_addr <= region_base + prod;
    end
  end

  // Turn the free address into a page index
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      dq <= (free_address - region_base) >> RW;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      page_address <= cmd.out_use_addr ? res_addr : '0;
      status       <= cmd.out_status;
    end
  end

endmodule

`default_nettype wire

/* rtl/pba_checker.sv */
`default_nettype none

module pba_checker
  import pba_pkg::*;
(
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                in_valid,
  input wire logic                in_stall,
  input wire logic                out_valid,
  input wire logic                out_stall,
  input wire logic [ADDR_W-1:0]   page_address,
  input wire logic [STATUS_W-1:0] status
);

  // Bitmap clearing blocks requests right after reset
  a_reset_blocks: assert property (@(posedge clk)
    rst |=> (in_stall && !out_valid))
    else $error("requests not blocked after reset");

  // Only one request in flight
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("second request taken while busy");

  // Address is zero on a failed request
  a_addr_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status != ST_OK)) |-> (page_address == '0))
    else $error("nonzero address on failed request");

  // Status is one of the defined codes
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((status == ST_OK) || (status == ST_NO_PAGE) || (status == ST_BAD_FREE)))
    else $error("undefined status code");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(page_address) && $stable(status)))
    else $error("stalled result changed");

endmodule

bind page_bitmap_allocator pba_checker u_pba_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .page_address (page_address),
  .status       (status)
);

`default_nettype wire
